/* sv/sfcd_pkg.sv */
// shared constants, register codes and types of the sbus frame channel decoder
package sfcd_pkg;

  localparam int unsigned StoreDepth = 22;   // frame bytes 1..22 hold channel data
  localparam int unsigned AddrW      = 5;
  localparam int unsigned PosW       = 5;
  localparam int unsigned LastPos    = 24;   // frame bytes 0..24
  localparam int unsigned NumChan    = 16;
  localparam int unsigned ChanIdxW   = 4;
  localparam int unsigned ChanW      = 11;
  localparam int unsigned BufW       = 18;   // up to 10 leftover bits plus one byte
  localparam int unsigned CntW       = 5;
  localparam int unsigned RegIdxW    = 8;

  localparam logic [PosW-1:0]  PosIdle     = 5'd31;
  localparam logic [7:0]       HeaderReset = 8'h0F;
  localparam logic [7:0]       FooterReset = 8'h00;

  typedef enum logic [RegIdxW-1:0] {
    REG_HEADER = 8'd0,
    REG_FOOTER = 8'd1
  } sfcd_reg_e;

  // frame store write request from the framer
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } sfcd_wr_t;

endpackage

/* sv/sfcd_intf.sv */
// valid/ready channel interfaces: received bytes, decoded channels, register writes
interface sfcd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfcd_ch_if;
  logic        valid;
  logic        ready;
  logic [3:0]  channel_index;
  logic [10:0] channel_value;
  logic        last_channel;

  modport source (output valid, output channel_index, output channel_value,
                  output last_channel, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input last_channel, output ready);
endinterface

interface sfcd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] reg_index;
  logic [7:0] reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

/* sv/sfcd_unpack.sv */
// frame store memory and bit unpacker that emits the sixteen 11-bit channels
module sfcd_unpack import sfcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sfcd_wr_t  wr_i,
  input  logic      start_i,
  output logic      busy_o,
  sfcd_ch_if.source ch_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_EMIT
  } state_e;

  state_e              state_q;
  logic [7:0]          mem_q [StoreDepth];
  logic [7:0]          rdata_q;
  logic [AddrW-1:0]    rd_addr_q;
  logic [BufW-1:0]     buf_q;
  logic [CntW-1:0]     nbits_q;
  logic [ChanIdxW-1:0] chan_q;
  logic                out_valid_q;
  logic [ChanIdxW-1:0] out_index_q;
  logic [ChanW-1:0]    out_value_q;
  logic                out_last_q;

  logic                slot_free;
  logic [BufW-1:0]     loaded;
  logic [CntW-1:0]     nbits_ld;
  logic [CntW-1:0]     nbits_left;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[rd_addr_q];
  end

  assign slot_free  = !out_valid_q || ch_o.ready;
  assign loaded     = buf_q | (BufW'(rdata_q) << nbits_q);
  assign nbits_ld   = nbits_q + CntW'(8);
  assign nbits_left = nbits_q - CntW'(ChanW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_addr_q   <= '0;
      buf_q       <= '0;
      nbits_q     <= '0;
      chan_q      <= '0;
      out_valid_q <= 1'b0;
      out_index_q <= '0;
      out_value_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // outside the emit state a taken item just leaves the output slot
      if (ch_o.ready && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            rd_addr_q <= '0;
            buf_q     <= '0;
            nbits_q   <= '0;
            chan_q    <= '0;
            state_q   <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          buf_q   <= loaded;
          nbits_q <= nbits_ld;
          if (rd_addr_q < AddrW'(StoreDepth - 1)) begin
            rd_addr_q <= rd_addr_q + AddrW'(1);
          end
          state_q <= (nbits_ld >= CntW'(ChanW)) ? S_EMIT : S_READ;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_index_q <= chan_q;
            out_value_q <= buf_q[ChanW-1:0];
            out_last_q  <= (chan_q == ChanIdxW'(NumChan - 1));
            buf_q       <= buf_q >> ChanW;
            nbits_q     <= nbits_left;
            chan_q      <= chan_q + ChanIdxW'(1);
            if (chan_q == ChanIdxW'(NumChan - 1)) begin
              state_q <= S_IDLE;
            end else if (nbits_left >= CntW'(ChanW)) begin
              state_q <= S_EMIT;
            end else begin
              state_q <= S_READ;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o             = (state_q != S_IDLE);
  assign ch_o.valid         = out_valid_q;
  assign ch_o.channel_index = out_index_q;
  assign ch_o.channel_value = out_value_q;
  assign ch_o.last_channel  = out_last_q;

endmodule

/* sv/sbus_frame_channel_decoder.sv */
// top level: sbus frame detection, frame byte capture and channel output
// operation: a non-final byte only moves the framer; the final frame byte starts a drain that
//   reads the 22 stored bytes in turn and emits the sixteen channels, stalling while ch_o is not ready
// throughput: one byte per cycle between frames; no byte is taken during the drain, which runs
//   all store reads and channels through the single unpack shifter
// reset: asynchronous active low; framer idle, previous byte zero, registers at defaults,
//   frame store contents left unknown until the next frame writes them
module sbus_frame_channel_decoder import sfcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfcd_cfg_if.sink   cfg_i,
  sfcd_rx_if.sink    rx_i,
  sfcd_ch_if.source  ch_o
);

  // configuration registers
  logic [7:0] header_q;
  logic [7:0] footer_q;

  // framer state
  logic [7:0]      prev_q;
  logic [PosW-1:0] pos_q;
  logic [PosW-1:0] pos_d;

  logic            rx_accept;
  logic            frame_start;
  logic [PosW-1:0] pos_eff;    // position this byte lands on
  logic            frame_done;
  logic            unpack_busy;
  sfcd_wr_t        store_wr;

  // register writes are always taken; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HeaderReset;
      footer_q <= FooterReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        REG_HEADER: header_q <= cfg_i.reg_data;
        REG_FOOTER: footer_q <= cfg_i.reg_data;
        default: ;
      endcase
    end
  end

  // bytes are held off while the unpacker drains a frame
  assign rx_i.ready = !unpack_busy;
  assign rx_accept  = rx_i.valid && rx_i.ready;

  // a frame only starts from idle: footer then header
  assign frame_start = (pos_q == PosIdle) && (prev_q == footer_q) &&
                       (rx_i.rx_byte == header_q);
  assign pos_eff     = frame_start ? '0 : pos_q;

  // bytes 1..22 carry the channel bits; header, flags and footer are not kept
  always_comb begin
    store_wr.en   = rx_accept && (pos_eff >= PosW'(1)) && (pos_eff <= PosW'(StoreDepth));
    store_wr.addr = AddrW'(pos_eff - PosW'(1));
    store_wr.data = rx_i.rx_byte;
  end

  assign frame_done = rx_accept && (pos_eff == PosW'(LastPos));

  always_comb begin
    if (pos_eff <= PosW'(LastPos)) begin
      pos_d = (pos_eff == PosW'(LastPos)) ? PosIdle : pos_eff + PosW'(1);
    end else begin
      pos_d = PosIdle;
    end
  end

  // previous byte tracks every byte so a frame may follow right after another
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      pos_q  <= PosIdle;
    end else if (rx_accept) begin
      prev_q <= rx_i.rx_byte;
      pos_q  <= pos_d;
    end
  end

  sfcd_unpack u_unpack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (store_wr),
    .start_i (frame_done),
    .busy_o  (unpack_busy),
    .ch_o    (ch_o)
  );

endmodule

/* sv/sfcd_checker.sv */
// port-level checker for the sbus frame channel decoder and its bind
module sfcd_checker import sfcd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                rx_ready,
  input logic                ch_valid,
  input logic                ch_ready,
  input logic [ChanIdxW-1:0] ch_index,
  input logic [ChanW-1:0]    ch_value,
  input logic                ch_last
);

  // a held channel item does not change under stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_valid && !ch_ready |=> ch_valid && $stable(ch_index) && $stable(ch_value) &&
    $stable(ch_last))
    else $error("channel item changed while stalled");

  // the last marker sits on channel fifteen only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_valid |-> (ch_last == (ch_index == ChanIdxW'(NumChan - 1))))
    else $error("last marker does not match channel index");

  // no byte is taken while a frame is still being emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_valid && !ch_last |-> !rx_ready)
    else $error("byte accepted in the middle of channel output");

  // channels come out in order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_valid && ch_ready && !ch_last |=>
      !ch_valid || (ch_index == ChanIdxW'($past(ch_index) + ChanIdxW'(1))))
    else $error("channel index out of order");

endmodule

bind sbus_frame_channel_decoder sfcd_checker u_sfcd_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .rx_ready (rx_i.ready),
  .ch_valid (ch_o.valid),
  .ch_ready (ch_o.ready),
  .ch_index (ch_o.channel_index),
  .ch_value (ch_o.channel_value),
  .ch_last  (ch_o.last_channel)
);
